>>> sv/pva_pkg.sv
`timescale 1ns / 1ps

package pva_pkg;

  localparam int LEVEL_W = 24;
  localparam int STAMP_W = 32;
  localparam int CFG_W   = 24;

  localparam logic [LEVEL_W-1:0] ONE_Q23 = 24'd8388608;

  // event kinds
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd2;
  localparam logic [1:0] KIND_ALL_OFF  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ATTACK  = 2'd0;
  localparam logic [1:0] CFG_DECAY   = 2'd1;
  localparam logic [1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [1:0] CFG_RELEASE = 2'd3;

  localparam logic [CFG_W-1:0] ATTACK_RST  = 24'd34953;
  localparam logic [CFG_W-1:0] DECAY_RST   = 24'd1165;
  localparam logic [CFG_W-1:0] SUSTAIN_RST = 24'd5872026;
  localparam logic [CFG_W-1:0] RELEASE_RST = 24'd874;

  typedef enum logic [2:0] {
    ST_ATTACK  = 3'd0,
    ST_DECAY   = 3'd1,
    ST_SUSTAIN = 3'd2,
    ST_RELEASE = 3'd3,
    ST_IDLE    = 3'd4
  } stage_t;

  // envelope settings handed to the step unit
  typedef struct packed {
    logic [CFG_W-1:0] attack_step;
    logic [CFG_W-1:0] decay_step;
    logic [CFG_W-1:0] sustain_level;
    logic [CFG_W-1:0] release_step;
  } env_cfg_t;

  // one voice record as kept in the voice memory
  typedef struct packed {
    logic               valid;
    logic [6:0]         key;
    logic [3:0]         chan;
    logic [6:0]         vel;
    stage_t             stage;
    logic [LEVEL_W-1:0] level;
    logic [STAMP_W-1:0] stamp;
  } voice_t;

  localparam voice_t VOICE_RESET = '{
    valid: 1'b0, key: 7'd0, chan: 4'd0, vel: 7'd0,
    stage: ST_IDLE, level: 24'd0, stamp: 32'd0
  };

endpackage

>>> sv/pva_env_step.sv
`timescale 1ns / 1ps

// one tick of the linear adsr envelope for a single voice
module pva_env_step (
  input  pva_pkg::env_cfg_t        cfg,
  input  pva_pkg::stage_t          stage_i,
  input  logic [pva_pkg::LEVEL_W-1:0] level_i,
  output pva_pkg::stage_t          stage_o,
  output logic [pva_pkg::LEVEL_W-1:0] level_o
);
  import pva_pkg::*;

  logic [LEVEL_W-1:0]        sus;
  logic [LEVEL_W:0]          att_sum;
  logic signed [LEVEL_W+1:0] dec_diff;
  logic signed [LEVEL_W+1:0] rel_diff;

  always_comb begin
    // sustain saturates at full scale
    sus      = (cfg.sustain_level > ONE_Q23) ? ONE_Q23 : cfg.sustain_level;
    att_sum  = {1'b0, level_i} + {1'b0, cfg.attack_step};
    dec_diff = $signed({2'b00, level_i}) - $signed({2'b00, cfg.decay_step});
    rel_diff = $signed({2'b00, level_i}) - $signed({2'b00, cfg.release_step});
    stage_o  = stage_i;
    level_o  = level_i;
    case (stage_i)
      ST_ATTACK: begin
        if (att_sum >= {1'b0, ONE_Q23}) begin
          level_o = ONE_Q23;
          stage_o = ST_DECAY;
        end else begin
          level_o = att_sum[LEVEL_W-1:0];
        end
      end
      ST_DECAY: begin
        if (dec_diff <= $signed({2'b00, sus})) begin
          level_o = sus;
          stage_o = ST_SUSTAIN;
        end else begin
          level_o = dec_diff[LEVEL_W-1:0];
        end
      end
      ST_SUSTAIN: begin
        level_o = sus;
      end
      ST_RELEASE: begin
        if (rel_diff <= $signed({(LEVEL_W+2){1'b0}})) begin
          level_o = '0;
          stage_o = ST_IDLE;
        end else begin
          level_o = rel_diff[LEVEL_W-1:0];
        end
      end
      default: begin
        level_o = level_i;
      end
    endcase
  end

endmodule

>>> sv/poly_voice_allocator_adsr.sv
`timescale 1ns / 1ps

// channel   direction  transfer when          payload
// in_       input      in_valid & in_ready    kind, midi_channel, note_key, note_velocity
// out_      output     out_valid & out_ready  one voice snapshot entry, NUM_VOICES per event
// cfg_      input      cfg_we                 register index and 24-bit data
//
// an event runs a read-modify-write pass over the voice memory, a pick state,
// then one snapshot entry per cycle read from the same single-read-port memory.
// after reset a clearing pass over every voice runs before in_ready rises.
// an output stall holds the snapshot pass; the next event is taken while the
// final entry still waits in the output register.
module poly_voice_allocator_adsr #(
  parameter int NUM_VOICES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [pva_pkg::CFG_W-1:0]     cfg_wdata,
  // event input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [3:0]                    in_midi_channel,
  input  logic [6:0]                    in_note_key,
  input  logic [6:0]                    in_note_velocity,
  // snapshot output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    out_voice_index,
  output logic                          out_voice_active,
  output logic [6:0]                    out_voice_key,
  output logic [3:0]                    out_voice_channel,
  output logic [6:0]                    out_voice_velocity,
  output logic [2:0]                    out_env_stage,
  output logic [pva_pkg::LEVEL_W-1:0]   out_env_level,
  output logic                          out_was_started,
  output logic                          out_last_voice
);
  import pva_pkg::*;

  localparam int IDX_W = $clog2(NUM_VOICES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PICK,
    S_EMIT
  } fsm_t;

  // configuration registers
  env_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_step   <= ATTACK_RST;
      cfg_r.decay_step    <= DECAY_RST;
      cfg_r.sustain_level <= SUSTAIN_RST;
      cfg_r.release_step  <= RELEASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK:  cfg_r.attack_step   <= cfg_wdata;
        CFG_DECAY:   cfg_r.decay_step    <= cfg_wdata;
        CFG_SUSTAIN: cfg_r.sustain_level <= cfg_wdata;
        CFG_RELEASE: cfg_r.release_step  <= cfg_wdata;
        default:     cfg_r.attack_step   <= cfg_r.attack_step;
      endcase
    end
  end

  // voice memory, one write and one registered read port
  voice_t             mem [NUM_VOICES];
  voice_t             rdata_r;
  voice_t             mem_wdata;
  logic               mem_we;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // envelope step on the entry just read
  stage_t             step_stage;
  logic [LEVEL_W-1:0] step_level;

  pva_env_step u_env_step (
    .cfg     (cfg_r),
    .stage_i (rdata_r.stage),
    .level_i (rdata_r.level),
    .stage_o (step_stage),
    .level_o (step_level)
  );

  // sequencer state
  fsm_t               state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [3:0]         chan_r, chan_nxt;
  logic [6:0]         key_r, key_nxt;
  logic [6:0]         vel_r, vel_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic               rel_found_r, rel_found_nxt;
  logic [IDX_W-1:0]   rel_idx_r, rel_idx_nxt;
  logic [LEVEL_W-1:0] rel_level_r, rel_level_nxt;
  logic [IDX_W-1:0]   old_idx_r, old_idx_nxt;
  logic [STAMP_W-1:0] old_stamp_r, old_stamp_nxt;
  logic [IDX_W-1:0]   started_r, started_nxt;
  logic               start_en_r, start_en_nxt;
  logic [STAMP_W-1:0] note_counter_r, note_counter_nxt;
  logic               out_valid_r, out_valid_nxt;
  voice_t             out_rec_r, out_rec_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic               out_started_r, out_started_nxt;
  logic               out_last_r, out_last_nxt;

  voice_t             upd;
  voice_t             ent;
  logic               last_idx;
  logic               start_hit;
  logic               out_load;

  assign last_idx  = (idx_r == IDX_W'(NUM_VOICES - 1));
  assign start_hit = start_en_r && (idx_r == started_r);
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // modify pass: the event's update applied to one voice
  always_comb begin
    upd = rdata_r;
    case (kind_r)
      KIND_TICK: begin
        if (rdata_r.valid) begin
          upd.stage = step_stage;
          upd.level = step_level;
          if (step_stage == ST_IDLE) begin
            upd.valid = 1'b0;
          end
        end
      end
      KIND_NOTE_ON, KIND_NOTE_OFF: begin
        if (rdata_r.valid && rdata_r.stage != ST_RELEASE &&
            rdata_r.key == key_r && rdata_r.chan == chan_r) begin
          upd.stage = ST_RELEASE;
        end
      end
      default: begin
        upd.valid = 1'b0;
        upd.stage = ST_IDLE;
        upd.level = '0;
      end
    endcase
  end

  // snapshot pass: the started voice takes the new note, keeps its level
  always_comb begin
    ent = rdata_r;
    if (start_hit) begin
      ent.valid = 1'b1;
      ent.key   = key_r;
      ent.chan  = chan_r;
      ent.vel   = vel_r;
      ent.stamp = note_counter_r;
      ent.stage = ST_ATTACK;
    end
  end

  // next-state logic
  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    kind_nxt         = kind_r;
    chan_nxt         = chan_r;
    key_nxt          = key_r;
    vel_nxt          = vel_r;
    free_found_nxt   = free_found_r;
    free_idx_nxt     = free_idx_r;
    rel_found_nxt    = rel_found_r;
    rel_idx_nxt      = rel_idx_r;
    rel_level_nxt    = rel_level_r;
    old_idx_nxt      = old_idx_r;
    old_stamp_nxt    = old_stamp_r;
    started_nxt      = started_r;
    start_en_nxt     = start_en_r;
    note_counter_nxt = note_counter_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_rec_nxt      = out_rec_r;
    out_idx_nxt      = out_idx_r;
    out_started_nxt  = out_started_r;
    out_last_nxt     = out_last_r;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_waddr        = idx_r;
    mem_raddr        = idx_r + IDX_W'(1);
    mem_wdata        = upd;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = VOICE_RESET;
        if (last_idx) begin
          state_nxt = S_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt       = in_kind;
          chan_nxt       = in_midi_channel;
          key_nxt        = in_note_key;
          vel_nxt        = in_note_velocity;
          free_found_nxt = 1'b0;
          rel_found_nxt  = 1'b0;
          mem_re         = 1'b1;
          mem_raddr      = '0;
          idx_nxt        = '0;
          state_nxt      = S_MOD;
        end
      end
      S_MOD: begin
        mem_we = 1'b1;
        // voice choice candidates, taken from the updated records
        if (!upd.valid && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = idx_r;
        end
        if (upd.stage == ST_RELEASE && (!rel_found_r || upd.level < rel_level_r)) begin
          rel_found_nxt = 1'b1;
          rel_idx_nxt   = idx_r;
          rel_level_nxt = upd.level;
        end
        if (idx_r == '0 || upd.stamp < old_stamp_r) begin
          old_idx_nxt   = idx_r;
          old_stamp_nxt = upd.stamp;
        end
        if (last_idx) begin
          state_nxt = S_PICK;
        end else begin
          mem_re  = 1'b1;
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_PICK: begin
        start_en_nxt = (kind_r == KIND_NOTE_ON);
        if (free_found_r) begin
          started_nxt = free_idx_r;
        end else if (rel_found_r) begin
          started_nxt = rel_idx_r;
        end else begin
          started_nxt = old_idx_r;
        end
        if (kind_r == KIND_NOTE_ON) begin
          note_counter_nxt = note_counter_r + STAMP_W'(1);
        end
        mem_re    = 1'b1;
        mem_raddr = '0;
        idx_nxt   = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt   = 1'b1;
          out_rec_nxt     = ent;
          out_idx_nxt     = idx_r;
          out_started_nxt = start_hit;
          out_last_nxt    = last_idx;
          if (start_hit) begin
            mem_we    = 1'b1;
            mem_wdata = ent;
          end
          if (last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re  = 1'b1;
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    chan_r        <= chan_nxt;
    key_r         <= key_nxt;
    vel_r         <= vel_nxt;
    free_idx_r    <= free_idx_nxt;
    rel_idx_r     <= rel_idx_nxt;
    rel_level_r   <= rel_level_nxt;
    old_idx_r     <= old_idx_nxt;
    old_stamp_r   <= old_stamp_nxt;
    started_r     <= started_nxt;
    out_rec_r     <= out_rec_nxt;
    out_idx_r     <= out_idx_nxt;
    out_started_r <= out_started_nxt;
    out_last_r    <= out_last_nxt;
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      idx_r          <= '0;
      free_found_r   <= 1'b0;
      rel_found_r    <= 1'b0;
      start_en_r     <= 1'b0;
      note_counter_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      idx_r          <= idx_nxt;
      free_found_r   <= free_found_nxt;
      rel_found_r    <= rel_found_nxt;
      start_en_r     <= start_en_nxt;
      note_counter_r <= note_counter_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_voice_index    = 4'(out_idx_r);
  assign out_voice_active   = out_rec_r.valid;
  assign out_voice_key      = out_rec_r.key;
  assign out_voice_channel  = out_rec_r.chan;
  assign out_voice_velocity = out_rec_r.vel;
  assign out_env_stage      = out_rec_r.stage;
  assign out_env_level      = out_rec_r.level;
  assign out_was_started    = out_started_r;
  assign out_last_voice     = out_last_r;

  // read and write never meet on one entry, so no forwarding is needed
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("voice memory read and write on the same entry");

  // levels written back never exceed full scale
  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_wdata.level <= ONE_Q23))
    else $error("envelope level above full scale");

  // a started flag only follows a note on
  a_start_on_note_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && start_hit) |-> (kind_r == KIND_NOTE_ON))
    else $error("voice started by an event that is not a note on");

  // the final snapshot entry returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_idx) |=> (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("final snapshot entry did not end the event");

  // no event is taken while a pass is running
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD || state_r == S_EMIT || state_r == S_CLEAR) |-> !in_ready)
    else $error("event input ready during a voice pass");

endmodule
